### design/glyph_line_renderer_assert.svh
// Assertion macros for the checker file of the glyph line renderer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef GLYPH_LINE_RENDERER_ASSERT_SVH
`define GLYPH_LINE_RENDERER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GLR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/glr_pkg.sv
// Shared constants and types of the glyph line renderer.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package glr_pkg;

    localparam int LINE_PIXELS  = 16;  // widest glyph line the datapath carries
    localparam int SIDE_W       = 5;   // glyph side, 1..16
    localparam int PIX_IDX_W    = 4;   // pixel / line counter
    localparam int G_W          = 9;   // glyph bit number, up to 16*16+16
    localparam int RED_W        = 16;  // signed store index before wrapping
    localparam int FIRST_CODE   = 32;  // first character code with a glyph
    localparam int HEADER_BYTES = 2;   // bytes ahead of the first glyph
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BASE      = 3'd0,
        REG_FRAME_WIDTH     = 3'd1,
        REG_FRAME_HEIGHT    = 3'd2,
        REG_PORTRAIT_MODE   = 3'd3,
        REG_TRANSPARENT_KEY = 3'd4,
        REG_GLYPH_WIDTH     = 3'd5,
        REG_GLYPH_HEIGHT    = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // Glyph side limited to 1..top
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                      input logic [SIDE_W-1:0] top);
        logic [SIDE_W-1:0] r;
        if (v == '0)
            r = SIDE_W'(1);
        else if (v > top)
            r = top;
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

### design/glr_if.sv
// Channel interfaces of the glyph line renderer: requests, line results, config.
// Depends on glr_pkg for the configuration widths.
`default_nettype none

interface glr_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [10:0] store_index;
    logic [7:0]  store_byte;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  char_code;
    logic [31:0] fore_color;
    logic [31:0] back_color;

    modport source (output valid, operation, store_index, store_byte, pos_x, pos_y,
                    char_code, fore_color, back_color, input ready);
    modport sink   (input valid, operation, store_index, store_byte, pos_x, pos_y,
                    char_code, fore_color, back_color, output ready);
    modport mon    (input valid, ready, operation, store_index, store_byte, pos_x,
                    pos_y, char_code, fore_color, back_color);
endinterface

interface glr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] line_address;
    logic [15:0] glyph_bits;
    logic [15:0] write_mask;
    logic [31:0] line_fore_color;
    logic [31:0] line_back_color;
    logic        last_line;

    modport source (output valid, line_address, glyph_bits, write_mask,
                    line_fore_color, line_back_color, last_line, input ready);
    modport sink   (input valid, line_address, glyph_bits, write_mask,
                    line_fore_color, line_back_color, last_line, output ready);
    modport mon    (input valid, ready, line_address, glyph_bits, write_mask,
                    line_fore_color, line_back_color, last_line);
endinterface

interface glr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [glr_pkg::CFG_IDX_W-1:0]  index;
    logic [glr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/glr_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module glr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/glyph_line_renderer.sv
// Glyph line renderer: bitmap font character generator for a 32-bit framebuffer.
// Depends on glr_pkg, glr_if (channel interfaces) and glr_ram (glyph store).
//
// Use: a request on cmd is either a load (writes one glyph store byte, no result)
// or a draw (one result per glyph line on res). cfg writes the seven registers
// and is always ready; write it only while the block is idle.
// Draw results: glyph_height lines of glyph_width pixels in landscape, or
// glyph_width columns of glyph_height pixels in portrait layout. Each result
// carries the line's byte address, glyph bits, write mask, both colours and a
// last-line flag.
// Sequence: cmd.ready is high only when the sequencer is idle. A load adds or
// subtracts the store size until its index lies within the store, then writes
// its byte. A draw passes ST_SETUP1 and ST_SETUP2, wraps the character's store
// offset the same way, then per line fetches its pixels in ST_PIXEL, waits for
// the last byte in ST_DRAIN and hands the line on in ST_EMIT: the glyph store
// has one read port and each pixel fetches its own byte, one per cycle.
// The output register holds a finished line while the next one is gathered; if
// res stalls, the sequencer waits at the end of that next line.
// Reset clears the sequencer, the output valid and the registers to their reset
// values. The glyph store is not cleared and must be loaded before drawing.
`default_nettype none

module glyph_line_renderer #(
    parameter int STORE_BYTES    = 2048,
    parameter int MAX_GLYPH_SIDE = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    glr_cfg_if.sink   cfg,
    glr_in_if.sink    cmd,
    glr_out_if.source res
);

    localparam int IDX_W    = $clog2(STORE_BYTES);
    localparam int SIDE_TOP = (MAX_GLYPH_SIDE < glr_pkg::LINE_PIXELS) ?
                              MAX_GLYPH_SIDE : glr_pkg::LINE_PIXELS;
    localparam int RED_W    = glr_pkg::RED_W;
    localparam int G_W      = glr_pkg::G_W;
    localparam int SIDE_W   = glr_pkg::SIDE_W;
    localparam int PIX_W    = glr_pkg::PIX_IDX_W;
    localparam int LP       = glr_pkg::LINE_PIXELS;

    localparam logic signed [RED_W-1:0] STORE_S     = RED_W'(STORE_BYTES);
    localparam logic [IDX_W:0]          STORE_U     = (IDX_W+1)'(STORE_BYTES);
    localparam logic [SIDE_W-1:0]       SIDE_TOP_V  = SIDE_W'(SIDE_TOP);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SETUP1 = 7'b0000010,
        ST_SETUP2 = 7'b0000100,
        ST_REDUCE = 7'b0001000,
        ST_PIXEL  = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    // configuration
    logic [31:0]       frame_base_reg;
    logic [15:0]       frame_width_reg;
    logic [15:0]       frame_height_reg;
    logic              portrait_reg;
    logic [31:0]       key_reg;
    logic [SIDE_W-1:0] gw_cfg_reg;
    logic [SIDE_W-1:0] gh_cfg_reg;

    // control
    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   pend_valid_reg, pend_valid_next;

    // request and working values
    logic                    op_reg, op_next;
    logic [7:0]              byte_reg, byte_next;
    logic [15:0]             px_reg, px_next;
    logic [15:0]             py_reg, py_next;
    logic [7:0]              code_reg, code_next;
    logic [31:0]             fore_reg, fore_next;
    logic [31:0]             back_reg, back_next;
    logic [SIDE_W-1:0]       fw_reg, fw_next;
    logic [SIDE_W-1:0]       fh_reg, fh_next;
    logic [8:0]              area_reg, area_next;
    logic [31:0]             prod_reg, prod_next;
    logic signed [RED_W-1:0] red_reg, red_next;
    logic [IDX_W-1:0]        base_mod_reg, base_mod_next;
    logic [G_W-1:0]          g_line_reg, g_line_next;
    logic [G_W-1:0]          g_reg, g_next;
    logic [PIX_W-1:0]        j_reg, j_next;
    logic [PIX_W-1:0]        line_reg, line_next;
    logic [SIDE_W-1:0]       lines_reg, lines_next;
    logic [SIDE_W-1:0]       pixels_reg, pixels_next;
    logic [SIDE_W-1:0]       step_reg, step_next;
    logic [31:0]             line_addr_reg, line_addr_next;
    logic                    fore_wr_reg, fore_wr_next;
    logic                    back_wr_reg, back_wr_next;
    logic [LP-1:0]           bits_reg, bits_next;
    logic [LP-1:0]           mask_reg, mask_next;
    logic [PIX_W-1:0]        pend_j_reg, pend_j_next;
    logic [2:0]              pend_bit_reg, pend_bit_next;

    // output register
    logic [31:0]   o_addr_reg, o_addr_next;
    logic [LP-1:0] o_bits_reg, o_bits_next;
    logic [LP-1:0] o_mask_reg, o_mask_next;
    logic [31:0]   o_fore_reg, o_fore_next;
    logic [31:0]   o_back_reg, o_back_next;
    logic          o_last_reg, o_last_next;

    // glyph store ports
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [7:0]       ram_rd_data;

    // combinational helpers
    logic [SIDE_W-1:0]       fw_c, fh_c;
    logic [15:0]             pa_c, pb_c, dim_c;
    logic [31:0]             offs_c;
    logic signed [RED_W-1:0] code_ext, bytes_ext;
    logic [IDX_W:0]          rd_sum;
    logic                    bit_v;
    logic                    last_c;
    logic                    slot_free;

    assign cfg.ready = 1'b1;
    assign cmd.ready = (state_reg == ST_IDLE);

    assign res.valid           = res_valid_reg;
    assign res.line_address    = o_addr_reg;
    assign res.glyph_bits      = o_bits_reg;
    assign res.write_mask      = o_mask_reg;
    assign res.line_fore_color = o_fore_reg;
    assign res.line_back_color = o_back_reg;
    assign res.last_line       = o_last_reg;

    glr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (byte_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        fw_c   = glr_pkg::clamp_side(gw_cfg_reg, SIDE_TOP_V);
        fh_c   = glr_pkg::clamp_side(gh_cfg_reg, SIDE_TOP_V);
        pa_c   = portrait_reg ? px_reg : py_reg;
        pb_c   = portrait_reg ? py_reg : px_reg;
        dim_c  = portrait_reg ? frame_height_reg : frame_width_reg;
        offs_c = prod_reg + 32'(pb_c);

        code_ext  = signed'(RED_W'(code_reg)) - signed'(RED_W'(glr_pkg::FIRST_CODE));
        bytes_ext = signed'(RED_W'(area_reg[8:3]));

        // store byte of the current glyph bit, wrapped once at the store size
        rd_sum = (IDX_W+1)'(base_mod_reg) + (IDX_W+1)'(g_reg[G_W-1:3])
               + (IDX_W+1)'(glr_pkg::HEADER_BYTES);
        if (rd_sum >= STORE_U)
            rd_sum = rd_sum - STORE_U;

        bit_v     = ram_rd_data[pend_bit_reg];
        last_c    = ({1'b0, line_reg} == (lines_reg - SIDE_W'(1)));
        slot_free = !res_valid_reg || res.ready;
    end

    always_comb
    begin
        state_next      = state_reg;
        res_valid_next  = res_valid_reg;
        pend_valid_next = 1'b0;
        op_next         = op_reg;
        byte_next       = byte_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        code_next       = code_reg;
        fore_next       = fore_reg;
        back_next       = back_reg;
        fw_next         = fw_reg;
        fh_next         = fh_reg;
        area_next       = area_reg;
        prod_next       = prod_reg;
        red_next        = red_reg;
        base_mod_next   = base_mod_reg;
        g_line_next     = g_line_reg;
        g_next          = g_reg;
        j_next          = j_reg;
        line_next       = line_reg;
        lines_next      = lines_reg;
        pixels_next     = pixels_reg;
        step_next       = step_reg;
        line_addr_next  = line_addr_reg;
        fore_wr_next    = fore_wr_reg;
        back_wr_next    = back_wr_reg;
        bits_next       = bits_reg;
        mask_next       = mask_reg;
        pend_j_next     = pend_j_reg;
        pend_bit_next   = pend_bit_reg;
        o_addr_next     = o_addr_reg;
        o_bits_next     = o_bits_reg;
        o_mask_next     = o_mask_reg;
        o_fore_next     = o_fore_reg;
        o_back_next     = o_back_reg;
        o_last_next     = o_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = red_reg[IDX_W-1:0];
        ram_rd_en       = 1'b0;
        ram_rd_addr     = rd_sum[IDX_W-1:0];

        if (res.ready)
            res_valid_next = 1'b0;

        // byte fetched last cycle lands in its pixel
        if (pend_valid_reg)
        begin
            bits_next[pend_j_reg] = bit_v;
            mask_next[pend_j_reg] = bit_v ? fore_wr_reg : back_wr_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next   = cmd.operation;
                    byte_next = cmd.store_byte;
                    px_next   = cmd.pos_x;
                    py_next   = cmd.pos_y;
                    code_next = cmd.char_code;
                    fore_next = cmd.fore_color;
                    back_next = cmd.back_color;
                    red_next  = signed'(RED_W'(cmd.store_index));
                    if (cmd.operation == glr_pkg::OP_LOAD)
                        state_next = ST_REDUCE;
                    else
                        state_next = ST_SETUP1;
                end
            end
            ST_SETUP1:
            begin
                fw_next    = fw_c;
                fh_next    = fh_c;
                area_next  = 9'(fw_c) * 9'(fh_c);
                prod_next  = 32'(pa_c) * 32'(dim_c);
                state_next = ST_SETUP2;
            end
            ST_SETUP2:
            begin
                red_next       = code_ext * bytes_ext;
                line_addr_next = frame_base_reg + {offs_c[29:0], 2'b00};
                g_line_next    = portrait_reg ? (G_W'(area_reg) + G_W'(fw_reg))
                                              : G_W'(fw_reg);
                lines_next     = portrait_reg ? fw_reg : fh_reg;
                pixels_next    = portrait_reg ? fh_reg : fw_reg;
                step_next      = portrait_reg ? fw_reg : SIDE_W'(1);
                fore_wr_next   = (fore_reg != key_reg);
                back_wr_next   = (back_reg != key_reg);
                state_next     = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // one add or subtract of the store size per cycle
                if (red_reg[RED_W-1])
                    red_next = red_reg + STORE_S;
                else if (red_reg >= STORE_S)
                    red_next = red_reg - STORE_S;
                else if (op_reg == glr_pkg::OP_LOAD)
                begin
                    ram_wr_en  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    base_mod_next = red_reg[IDX_W-1:0];
                    g_next        = g_line_reg;
                    j_next        = '0;
                    line_next     = '0;
                    bits_next     = '0;
                    mask_next     = '0;
                    state_next    = ST_PIXEL;
                end
            end
            ST_PIXEL:
            begin
                ram_rd_en       = 1'b1;
                pend_valid_next = 1'b1;
                pend_j_next     = j_reg;
                pend_bit_next   = g_reg[2:0];
                j_next          = j_reg + PIX_W'(1);
                g_next          = g_reg - G_W'(step_reg);
                if ({1'b0, j_reg} == (pixels_reg - SIDE_W'(1)))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    o_addr_next    = line_addr_reg;
                    o_bits_next    = bits_reg;
                    o_mask_next    = mask_reg;
                    o_fore_next    = fore_reg;
                    o_back_next    = back_reg;
                    o_last_next    = last_c;
                    if (last_c)
                        state_next = ST_IDLE;
                    else
                    begin
                        line_next      = line_reg + PIX_W'(1);
                        line_addr_next = line_addr_reg + 32'({dim_c, 2'b00});
                        g_line_next    = portrait_reg ? (g_line_reg - G_W'(1))
                                                      : (g_line_reg + G_W'(fw_reg));
                        g_next         = portrait_reg ? (g_line_reg - G_W'(1))
                                                      : (g_line_reg + G_W'(fw_reg));
                        j_next         = '0;
                        bits_next      = '0;
                        mask_next      = '0;
                        state_next     = ST_PIXEL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            res_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
            frame_base_reg   <= '0;
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            portrait_reg     <= 1'b0;
            key_reg          <= '0;
            gw_cfg_reg       <= SIDE_W'(8);
            gh_cfg_reg       <= SIDE_W'(14);
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    glr_pkg::REG_FRAME_BASE:      frame_base_reg   <= cfg.data;
                    glr_pkg::REG_FRAME_WIDTH:     frame_width_reg  <= cfg.data[15:0];
                    glr_pkg::REG_FRAME_HEIGHT:    frame_height_reg <= cfg.data[15:0];
                    glr_pkg::REG_PORTRAIT_MODE:   portrait_reg     <= cfg.data[0];
                    glr_pkg::REG_TRANSPARENT_KEY: key_reg          <= cfg.data;
                    glr_pkg::REG_GLYPH_WIDTH:     gw_cfg_reg       <= cfg.data[SIDE_W-1:0];
                    glr_pkg::REG_GLYPH_HEIGHT:    gh_cfg_reg       <= cfg.data[SIDE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        byte_reg      <= byte_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        code_reg      <= code_next;
        fore_reg      <= fore_next;
        back_reg      <= back_next;
        fw_reg        <= fw_next;
        fh_reg        <= fh_next;
        area_reg      <= area_next;
        prod_reg      <= prod_next;
        red_reg       <= red_next;
        base_mod_reg  <= base_mod_next;
        g_line_reg    <= g_line_next;
        g_reg         <= g_next;
        j_reg         <= j_next;
        line_reg      <= line_next;
        lines_reg     <= lines_next;
        pixels_reg    <= pixels_next;
        step_reg      <= step_next;
        line_addr_reg <= line_addr_next;
        fore_wr_reg   <= fore_wr_next;
        back_wr_reg   <= back_wr_next;
        bits_reg      <= bits_next;
        mask_reg      <= mask_next;
        pend_j_reg    <= pend_j_next;
        pend_bit_reg  <= pend_bit_next;
        o_addr_reg    <= o_addr_next;
        o_bits_reg    <= o_bits_next;
        o_mask_reg    <= o_mask_next;
        o_fore_reg    <= o_fore_next;
        o_back_reg    <= o_back_next;
        o_last_reg    <= o_last_next;
    end

endmodule

`default_nettype wire

### design/glr_checker.sv
// Port-level checks for the glyph line renderer, bound to the top level.
// Depends on glr_if and glyph_line_renderer_assert.svh.
`default_nettype none

`include "glyph_line_renderer_assert.svh"

module glr_checker (
    input logic       clk,
    input logic       rst_n,
    glr_in_if.sink    cmd,
    glr_out_if.source res
);

    // the sequencer is always busy in the cycle after it takes a request
    `GLR_ASSERT_NEXT(a_busy_after_request, cmd.valid && cmd.ready, !cmd.ready, "ready straight after a request")

    // lines still to come, so the sequencer cannot be idle
    `GLR_ASSERT_SAME(a_busy_mid_char, res.valid && res.ready && !res.last_line, !cmd.ready, "idle with lines outstanding")

    // when idle, only the final line of a character may still wait
    `GLR_ASSERT_SAME(a_idle_only_last, cmd.ready && res.valid, res.last_line, "idle holding a non-final line")

    `GLR_ASSERT_NEXT(a_res_hold, res.valid && !res.ready, res.valid && $stable(res.line_address) && $stable(res.glyph_bits), "stalled line changed")

endmodule

bind glyph_line_renderer glr_checker u_glr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
);

`default_nettype wire
